// ----- rtl/core/serial_3964r_frame_receiver_assert.svh -----
// Assertion macros for the 3964R receiver.
// Both expect clk and rst_n in scope at the point of use.
`ifndef SERIAL_3964R_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_3964R_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define S3964_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("3964R receiver: same-cycle check failed");

// Next-cycle implication.
`define S3964_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("3964R receiver: next-cycle check failed");

`else

`define S3964_ASSERT_NOW(lbl, ante, cons)
`define S3964_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/s3964_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package s3964_pkg;

  // Line characters
  localparam logic [7:0] STX = 8'd2;
  localparam logic [7:0] ETX = 8'd3;
  localparam logic [7:0] DLE = 8'd16;
  localparam logic [7:0] NAK = 8'd21;

  // Telegram buffer size and the usable payload cap
  localparam int unsigned FRAME_BYTES = 2048;
  localparam int unsigned PAYLOAD_CAP = FRAME_BYTES - 10;

  // Input kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  // Link phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_BCC  = 2'd3;

  // Result kinds
  localparam logic [1:0] RK_DATA  = 2'd0;
  localparam logic [1:0] RK_REPLY = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;

  // Reply codes
  localparam logic [1:0] RP_NONE = 2'd0;
  localparam logic [1:0] RP_DLE  = 2'd1;
  localparam logic [1:0] RP_NAK  = 2'd2;

  // Frame status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BCC      = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_BADSTART = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_ACK_BAD = 2'd1;
  localparam logic [1:0] CFG_MAX_PL  = 2'd2;

  // Result queue depth (bundles)
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  data_byte;
    logic [1:0]  reply;
    logic [2:0]  status;
    logic [15:0] error_total;
  } res_t;

  // Everything one input item produces: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_t mk_res(input logic [1:0] k, input logic [7:0] d,
                                  input logic [1:0] r, input logic [2:0] s,
                                  input logic [15:0] e);
    res_t x;
    x.out_kind    = k;
    x.data_byte   = d;
    x.reply       = r;
    x.status      = s;
    x.error_total = e;
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/s3964_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module s3964_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_fire,
  input  wire logic              in_kind,
  input  wire logic [7:0]        in_byte,
  output      logic              push,
  output      s3964_pkg::bundle_t push_data,
  output      logic [1:0]        phase
);
  import s3964_pkg::*;

  localparam logic [16:0] CapWide = 17'(PAYLOAD_CAP);

  logic [15:0] timeout_r;
  logic        ack_bad_r;
  logic [10:0] max_pl_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  bcc_r, bcc_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] err_r, err_nxt;

  logic [10:0] limit;
  logic        at_lim, at_lim2;
  logic [15:0] err_inc, ticks_inc;
  logic        has;
  bundle_t     bnd;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd1000;
      ack_bad_r <= 1'b0;
      max_pl_r  <= 11'd2038;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_ACK_BAD: ack_bad_r <= cfg_wdata[0];
        CFG_MAX_PL:  max_pl_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign limit   = ({6'd0, max_pl_r} < CapWide) ? max_pl_r : CapWide[10:0];
  assign at_lim  = cnt_r >= limit;
  assign at_lim2 = ({1'b0, cnt_r} + 12'd1) >= {1'b0, limit};
  assign err_inc   = (err_r != 16'hFFFF) ? err_r + 16'd1 : err_r;
  assign ticks_inc = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;

  always_comb begin
    phase_nxt = phase_r;
    bcc_nxt   = bcc_r;
    cnt_nxt   = cnt_r;
    ticks_nxt = ticks_r;
    err_nxt   = err_r;
    has       = 1'b0;
    bnd       = '0;
    if (in_kind == IN_TICK) begin
      if (phase_r != PH_IDLE) begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= timeout_r) begin
          phase_nxt = PH_IDLE;
          ticks_nxt = '0;
          err_nxt   = err_inc;
          has       = 1'b1;
          bnd.r0    = mk_res(RK_END, 8'd0, RP_NONE, ST_TIMEOUT, err_inc);
        end
      end
    end else begin
      if (phase_r != PH_IDLE) ticks_nxt = '0;
      has = 1'b1;
      case (phase_r)
        PH_IDLE: begin
          if (in_byte == STX) begin
            phase_nxt = PH_DATA;
            bcc_nxt   = DLE ^ ETX;
            cnt_nxt   = '0;
            ticks_nxt = '0;
            bnd.r0    = mk_res(RK_REPLY, 8'd0, RP_DLE, ST_OK, err_r);
          end else begin
            ticks_nxt = '0;
            err_nxt   = err_inc;
            bnd.r0    = mk_res(RK_END, 8'd0, (in_byte == NAK) ? RP_NONE : RP_NAK,
                               ST_BADSTART, err_inc);
          end
        end
        PH_DATA: begin
          if (in_byte == DLE) begin
            phase_nxt = PH_ESC;
            has       = 1'b0;
          end else if (at_lim) begin
            phase_nxt = PH_IDLE;
            err_nxt   = err_inc;
            bnd.r0    = mk_res(RK_END, 8'd0, RP_NONE, ST_OVERFLOW, err_inc);
          end else begin
            cnt_nxt = cnt_r + 11'd1;
            bcc_nxt = bcc_r ^ in_byte;
            bnd.r0  = mk_res(RK_DATA, in_byte, RP_NONE, ST_OK, err_r);
          end
        end
        PH_ESC: begin
          phase_nxt = PH_DATA;
          if (in_byte == ETX) begin
            phase_nxt = PH_BCC;
            has       = 1'b0;
          end else if (at_lim) begin
            phase_nxt = PH_IDLE;
            err_nxt   = err_inc;
            bnd.r0    = mk_res(RK_END, 8'd0, RP_NONE, ST_OVERFLOW, err_inc);
          end else if (in_byte == DLE) begin
            cnt_nxt = cnt_r + 11'd1;
            bnd.r0  = mk_res(RK_DATA, DLE, RP_NONE, ST_OK, err_r);
          end else if (at_lim2) begin
            // lenient escape: the stuffed DLE fits, the byte after it does not
            phase_nxt = PH_IDLE;
            cnt_nxt   = cnt_r + 11'd1;
            err_nxt   = err_inc;
            bnd.two   = 1'b1;
            bnd.r0    = mk_res(RK_DATA, DLE, RP_NONE, ST_OK, err_r);
            bnd.r1    = mk_res(RK_END, 8'd0, RP_NONE, ST_OVERFLOW, err_inc);
          end else begin
            cnt_nxt = cnt_r + 11'd2;
            bcc_nxt = bcc_r ^ in_byte;
            bnd.two = 1'b1;
            bnd.r0  = mk_res(RK_DATA, DLE, RP_NONE, ST_OK, err_r);
            bnd.r1  = mk_res(RK_DATA, in_byte, RP_NONE, ST_OK, err_r);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_byte == bcc_r) begin
            bnd.r0 = mk_res(RK_END, 8'd0, RP_DLE, ST_OK, err_r);
          end else begin
            err_nxt = err_inc;
            bnd.r0  = mk_res(RK_END, 8'd0, ack_bad_r ? RP_DLE : RP_NONE, ST_BCC, err_inc);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bcc_r   <= '0;
      cnt_r   <= '0;
      ticks_r <= '0;
      err_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      bcc_r   <= bcc_nxt;
      cnt_r   <= cnt_nxt;
      ticks_r <= ticks_nxt;
      err_r   <= err_nxt;
    end
  end

  assign push      = in_fire & has;
  assign push_data = bnd;
  assign phase     = phase_r;

endmodule

`default_nettype wire

// ----- rtl/core/s3964_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module s3964_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire s3964_pkg::bundle_t wdata,
  input  wire logic               pop,
  output      s3964_pkg::bundle_t rdata,
  output      s3964_pkg::q_stat_t stat
);
  import s3964_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW:0] DepthC = (AW + 1)'(QUEUE_DEPTH);

  bundle_t         mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (AW + 1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc_ptr(wp_r);
      if (pop)  rp_r <= inc_ptr(rp_r);
      cnt_r <= cnt_nxt;
    end
  end

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == DepthC);
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/s3964_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module s3964_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire s3964_pkg::bundle_t head,
  input  wire s3964_pkg::q_stat_t q_stat,
  output      logic               pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      s3964_pkg::res_t    out_res,
  output      logic               out_last
);
  import s3964_pkg::*;

  logic valid_r, sel_r;
  res_t res_r;
  logic last_r;
  logic load;

  assign load = !valid_r || out_ready;
  assign pop  = load && !q_stat.empty && (sel_r || !head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (load) begin
      valid_r <= !q_stat.empty;
      if (!q_stat.empty) sel_r <= !sel_r && head.two;
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= sel_r ? head.r1 : head.r0;
      last_r <= sel_r || !head.two;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/serial_3964r_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Beat contents
// in_       in   tvalid/tready      tuser: kind; tdata: rx_byte
// out_      out  tvalid/tready      tuser: out_kind; tlast: last;
//                                   tdata: data_byte, reply, status, error_total
// cfg_      in   we (no wait)       addr: register index; wdata: value
//
// One input beat per cycle is taken while the result queue has room; the
// protocol state machine decides the whole item in that cycle.
// Results leave through a registered output stage that sits behind the queue;
// an item with two results leaves as two output beats, the first one first.
// rst_n is synchronous: it empties the queue and returns the link to idle.
// A stall on out_ fills the four-bundle queue before in_tready drops.

module serial_3964r_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic        in_tuser,   // [0] kind
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [1:0]  out_tuser,  // [1:0] out_kind
  output      logic        out_tlast,
  output      logic [31:0] out_tdata   // [7:0] data_byte, [9:8] reply,
                                       // [12:10] status, [28:13] error_total
);
  import s3964_pkg::*;

  `include "serial_3964r_frame_receiver_assert.svh"

  logic    in_fire;
  logic    push, pop;
  bundle_t push_data, head;
  q_stat_t q_stat;
  res_t    res;
  logic [1:0] phase;

  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  // front: protocol decode, one beat per cycle while the queue has room
  s3964_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata),
    .push      (push),
    .push_data (push_data),
    .phase     (phase)
  );

  // decoupling queue of result bundles
  s3964_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (head),
    .stat  (q_stat)
  );

  // back: splits bundles into output beats
  s3964_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tuser = res.out_kind;
  assign out_tdata = {3'd0, res.error_total, res.status, res.reply, res.data_byte};

  // a reply-only result is always alone
  `S3964_ASSERT_NOW(a_reply_alone, out_tvalid && res.out_kind == RK_REPLY, out_tlast)
  // payload beats carry no reply and no status
  `S3964_ASSERT_NOW(a_data_clean, out_tvalid && res.out_kind == RK_DATA,
                    res.reply == RP_NONE && res.status == ST_OK)
  // a good frame end is always acknowledged
  `S3964_ASSERT_NOW(a_ok_ack, out_tvalid && res.out_kind == RK_END && res.status == ST_OK,
                    res.reply == RP_DLE)
  // the second half of a two-result bundle follows straight on
  `S3964_ASSERT_NEXT(a_pair_tight, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // STX while idle opens a frame
  `S3964_ASSERT_NEXT(a_stx_opens,
                     in_fire && in_tuser == IN_BYTE && in_tdata == STX && phase == PH_IDLE,
                     phase == PH_DATA)

endmodule

`default_nettype wire
